>>> rtl/core/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared sizes, types and helpers of the grid map thinning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmt_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 9;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int PASS_W     = 5;
    localparam int MAXP_W     = 4;
    localparam int RING_N     = 8;
    localparam int K_W        = 4;
    localparam int CNT_W      = 4;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PASSES = 2'd2;

    typedef enum logic [2:0] {
        E_IDLE,
        E_COPY,
        E_COPY_END,
        E_SCAN_RD,
        E_SCAN_LAST,
        E_EVAL,
        E_SUB_END,
        E_DONE
    } t_eng_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_img_req;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        f_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
    endfunction

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
        if (v == '0) begin
            f_clamp = DIM_W'(1);
        end else if (v > hi) begin
            f_clamp = hi;
        end else begin
            f_clamp = v;
        end
    endfunction

endpackage

>>> rtl/core/grid_map_thinning.sv
// ----------------------------------------------------------------------------
// grid_map_thinning
// Grid image store with load, read-back and crossing-number thinning.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: op 0 loads a pixel, op 1 runs the
// thinning, op 2 reads a pixel back, op 3 does nothing. Every item gives
// one result item on m_axis: the pixel for a read (zero otherwise), the
// changed flag and pass count of the last run.
// Load, read and no-op items pass from the pending register into the result
// register; s_axis_tready stays low while an item is pending or a run is busy,
// so the block takes a new item only once the last has reached the result register.
// A run sweeps the frame through the image RAM and a snapshot RAM: each
// pass does two sub-iterations, each a copy of w*h pixels into the snapshot
// and a scan of the (w-2)*(h-2) interior pixels, which fetches each pixel's
// ring and centre from the snapshot, then clears it in the image if it passes;
// a frame below three rows or columns finishes without a sweep.
// The config channel is always ready; write it only while idle.
// Reset clears control state and the last run's status; the image memory
// holds no defined contents until loaded.
// While a result waits with m_axis_tready low, it holds and no new item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_map_thinning (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op[1:0], col[9:2], row[17:10], pixel_in[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_out[7:0], changed[8], passes_done[13:9]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import gmt_pkg::*;

    logic [1:0]        in_op;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic [PIX_W-1:0]  in_pix;
    logic              in_acc, in_inside;
    logic [ADDR_W-1:0] in_addr;

    logic [DIM_W-1:0]  r_width, r_height;
    logic [MAXP_W-1:0] r_max_passes;

    logic              r_p_vld;
    logic [1:0]        r_p_op;
    logic              r_p_inside;

    logic              r_out_vld;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_chg;
    logic [PASS_W-1:0] r_out_pass;

    t_img_req          eng_req, img_req;
    logic              eng_busy, eng_chg;
    logic [PASS_W-1:0] eng_pass;
    logic [PIX_W-1:0]  img_rdata;
    logic              emit;

    assign in_op     = s_axis_tdata[1:0];
    assign in_col    = s_axis_tdata[9:2];
    assign in_row    = s_axis_tdata[17:10];
    assign in_pix    = s_axis_tdata[25:18];
    assign in_inside = (DIM_W'(in_col) < DIM_W'(MAX_WIDTH)) &&
                       (DIM_W'(in_row) < DIM_W'(MAX_HEIGHT));
    assign in_addr   = f_addr(in_row, in_col);

    assign s_axis_tready = !r_p_vld && !eng_busy && (!r_out_vld || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign emit          = r_p_vld && !eng_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= DIM_W'(256);
            r_height     <= DIM_W'(256);
            r_max_passes <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width      <= i_cfg_data;
                REG_HEIGHT: r_height     <= i_cfg_data;
                REG_PASSES: r_max_passes <= i_cfg_data[MAXP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gmt_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_acc && (in_op == OP_RUN)),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_max_passes (r_max_passes),
        .i_img_rdata  (img_rdata),
        .o_img_req    (eng_req),
        .o_busy       (eng_busy),
        .o_changed    (eng_chg),
        .o_passes     (eng_pass)
    );

    always_comb begin
        if (eng_busy) begin
            img_req = eng_req;
        end else begin
            img_req.we    = in_acc && (in_op == OP_LOAD) && in_inside;
            img_req.waddr = in_addr;
            img_req.wdata = in_pix;
            img_req.raddr = in_addr;
        end
    end

    gmt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_image (
        .i_clk   (i_clk),
        .i_we    (img_req.we),
        .i_waddr (img_req.waddr),
        .i_wdata (img_req.wdata),
        .i_raddr (img_req.raddr),
        .o_rdata (img_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_p_vld <= 1'b1;
            end else if (emit) begin
                r_p_vld <= 1'b0;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_op     <= in_op;
            r_p_inside <= in_inside;
        end
        if (emit) begin
            r_out_pix  <= (r_p_op == OP_READ && r_p_inside) ? img_rdata : '0;
            r_out_chg  <= eng_chg;
            r_out_pass <= eng_pass;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_pass, r_out_chg, r_out_pix};

endmodule

>>> rtl/core/gmt_ram.sv
// ----------------------------------------------------------------------------
// gmt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/gmt_engine.sv
// ----------------------------------------------------------------------------
// gmt_engine
// Thinning sequencer: snapshot copy, ring fetch, decision and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmt_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gmt_pkg::DIM_W-1:0]   i_width,
    input  logic [gmt_pkg::DIM_W-1:0]   i_height,
    input  logic [gmt_pkg::MAXP_W-1:0]  i_max_passes,
    input  logic [gmt_pkg::PIX_W-1:0]   i_img_rdata,
    output gmt_pkg::t_img_req           o_img_req,
    output logic                        o_busy,
    output logic                        o_changed,
    output logic [gmt_pkg::PASS_W-1:0]  o_passes
);
    import gmt_pkg::*;

    t_eng_state         r_state, n_state;
    logic [DIM_W-1:0]   r_w, r_h;
    logic [MAXP_W-1:0]  r_max;
    logic [COL_W-1:0]   r_x;
    logic [ROW_W-1:0]   r_y;
    logic [K_W-1:0]     r_k, r_k_d;
    logic               r_rd_vld;
    logic               r_cp_vld;
    logic [ADDR_W-1:0]  r_cp_addr;
    logic [PIX_W-1:0]   r_ring [RING_N];
    logic [PIX_W-1:0]   r_center;
    logic               r_sub, r_any;
    logic [PASS_W-1:0]  r_pass;
    logic               r_changed;
    logic [PASS_W-1:0]  r_passes;

    logic [DIM_W-1:0]   w_cl, h_cl;
    logic               copy_last, scan_last_px, no_interior;
    logic [1:0]         dy, dx;
    logic [ROW_W-1:0]   nb_row;
    logic [COL_W-1:0]   nb_col;
    logic [ADDR_W-1:0]  cur_addr, nb_addr;
    logic               snap_we;
    logic [PIX_W-1:0]   snap_rdata;
    logic [CNT_W-1:0]   trans, zeros;
    logic               clear_px;
    logic [PASS_W-1:0]  pass_next;
    logic               stop;

    assign w_cl        = f_clamp(i_width, DIM_W'(MAX_WIDTH));
    assign h_cl        = f_clamp(i_height, DIM_W'(MAX_HEIGHT));
    assign no_interior = (w_cl < DIM_W'(3)) || (h_cl < DIM_W'(3));

    assign copy_last    = (DIM_W'(r_x) == r_w - DIM_W'(1)) &&
                          (DIM_W'(r_y) == r_h - DIM_W'(1));
    assign scan_last_px = (DIM_W'(r_x) == r_w - DIM_W'(2)) &&
                          (DIM_W'(r_y) == r_h - DIM_W'(2));

    assign pass_next = r_pass + PASS_W'(1);
    assign stop      = !r_any || (pass_next > PASS_W'(r_max));

    always_comb begin
        case (r_k)
            K_W'(0): begin dy = 2'd0; dx = 2'd0; end
            K_W'(1): begin dy = 2'd0; dx = 2'd1; end
            K_W'(2): begin dy = 2'd0; dx = 2'd2; end
            K_W'(3): begin dy = 2'd1; dx = 2'd2; end
            K_W'(4): begin dy = 2'd2; dx = 2'd2; end
            K_W'(5): begin dy = 2'd2; dx = 2'd1; end
            K_W'(6): begin dy = 2'd2; dx = 2'd0; end
            K_W'(7): begin dy = 2'd1; dx = 2'd0; end
            default: begin dy = 2'd1; dx = 2'd1; end
        endcase
    end

    assign nb_row   = r_y + ROW_W'(dy) - ROW_W'(1);
    assign nb_col   = r_x + COL_W'(dx) - COL_W'(1);
    assign nb_addr  = f_addr(nb_row, nb_col);
    assign cur_addr = f_addr(r_y, r_x);

    always_comb begin
        trans = '0;
        zeros = '0;
        for (int k = 0; k < RING_N; k++) begin
            if (r_ring[k] != r_ring[(k + 1) % RING_N]) begin
                trans = trans + CNT_W'(1);
            end
            if (r_ring[k] == '0) begin
                zeros = zeros + CNT_W'(1);
            end
        end
    end

    assign clear_px = (r_center != '0) && (trans inside {[1:3]}) && (zeros inside {[2:6]});

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_state = no_interior ? E_DONE : E_COPY;
                end
            end
            E_COPY: begin
                if (copy_last) begin
                    n_state = E_COPY_END;
                end
            end
            E_COPY_END:  n_state = E_SCAN_RD;
            E_SCAN_RD: begin
                if (r_k == K_W'(RING_N)) begin
                    n_state = E_SCAN_LAST;
                end
            end
            E_SCAN_LAST: n_state = E_EVAL;
            E_EVAL:      n_state = scan_last_px ? E_SUB_END : E_SCAN_RD;
            E_SUB_END: begin
                if (r_sub && stop) begin
                    n_state = E_DONE;
                end else begin
                    n_state = E_COPY;
                end
            end
            E_DONE:      n_state = E_IDLE;
            default:     n_state = E_IDLE;
        endcase
    end

    always_comb begin
        o_img_req.we    = 1'b0;
        o_img_req.waddr = cur_addr;
        o_img_req.wdata = '0;
        o_img_req.raddr = cur_addr;
        case (r_state)
            E_EVAL:  o_img_req.we = clear_px;
            default: o_img_req.we = 1'b0;
        endcase
    end

    assign snap_we = r_cp_vld;

    gmt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_snap (
        .i_clk   (i_clk),
        .i_we    (snap_we),
        .i_waddr (r_cp_addr),
        .i_wdata (i_img_rdata),
        .i_raddr (nb_addr),
        .o_rdata (snap_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= E_IDLE;
            r_cp_vld  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_changed <= 1'b0;
            r_passes  <= '0;
            r_sub     <= 1'b0;
            r_any     <= 1'b0;
            r_pass    <= '0;
            r_k       <= '0;
            r_x       <= '0;
            r_y       <= '0;
        end else begin
            r_state  <= n_state;
            r_cp_vld <= (r_state == E_COPY);
            r_rd_vld <= (r_state == E_SCAN_RD);
            if (r_state == E_COPY) begin
                r_cp_addr <= cur_addr;
            end
            r_k_d <= r_k;
            if (r_rd_vld) begin
                if (r_k_d == K_W'(RING_N)) begin
                    r_center <= snap_rdata;
                end else begin
                    r_ring[r_k_d[2:0]] <= snap_rdata;
                end
            end
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_w    <= w_cl;
                        r_h    <= h_cl;
                        r_max  <= i_max_passes;
                        r_pass <= '0;
                        r_sub  <= 1'b0;
                        r_any  <= 1'b0;
                        r_x    <= '0;
                        r_y    <= '0;
                        if (no_interior) begin
                            r_changed <= 1'b0;
                            r_passes  <= PASS_W'(1);
                        end
                    end
                end
                E_COPY: begin
                    if (DIM_W'(r_x) == r_w - DIM_W'(1)) begin
                        r_x <= '0;
                        r_y <= r_y + ROW_W'(1);
                    end else begin
                        r_x <= r_x + COL_W'(1);
                    end
                end
                E_COPY_END: begin
                    r_x <= COL_W'(1);
                    r_y <= ROW_W'(1);
                    r_k <= '0;
                end
                E_SCAN_RD: begin
                    r_k <= r_k + K_W'(1);
                end
                E_EVAL: begin
                    r_k <= '0;
                    if (clear_px) begin
                        r_any <= 1'b1;
                    end
                    if (DIM_W'(r_x) == r_w - DIM_W'(2)) begin
                        r_x <= COL_W'(1);
                        r_y <= r_y + ROW_W'(1);
                    end else begin
                        r_x <= r_x + COL_W'(1);
                    end
                end
                E_SUB_END: begin
                    r_x <= '0;
                    r_y <= '0;
                    if (!r_sub) begin
                        r_sub <= 1'b1;
                    end else if (stop) begin
                        r_changed <= r_any;
                        r_passes  <= pass_next;
                    end else begin
                        r_pass <= pass_next;
                        r_sub  <= 1'b0;
                        r_any  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy    = (r_state != E_IDLE);
    assign o_changed = r_changed;
    assign o_passes  = r_passes;

endmodule

>>> rtl/core/gmt_checker.sv
// ----------------------------------------------------------------------------
// gmt_checker
// Port-level checks of the grid map thinning block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while previous one pending");

    a_short_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] != 2'd1)
        |-> ##2 m_axis_tvalid)
        else $error("load or read result late");

    a_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:9] <= 5'd16) &&
                          (!m_axis_tdata[8] || (m_axis_tdata[13:9] != 5'd0)))
        else $error("run status out of range");

endmodule

bind grid_map_thinning gmt_checker u_gmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/grid_map_thinning_checker.sv
// ----------------------------------------------------------------------------
// grid_map_thinning_checker
// Watches the item, result and register channels of the thinning block,
// keeps its own copy of the image and status, predicts every result item
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_map_thinning_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [31:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [15:0] i_m_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    import gmt_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]  pixel;
        logic              changed;
        logic [PASS_W-1:0] passes;
    } t_status;

    logic [PIX_W-1:0]  img  [MAX_WIDTH*MAX_HEIGHT];
    logic [PIX_W-1:0]  snap [MAX_WIDTH*MAX_HEIGHT];
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [MAXP_W-1:0] passes_reg;
    logic              run_changed;
    logic [PASS_W-1:0] run_passes;
    t_status           expected_q[$];

    function automatic int size_clamp(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit thin_half(input int w, input int h);
        bit          any;
        int          trans, zeros;
        logic [7:0]  ring [8];
        any = 0;
        if (w < 3 || h < 3) return 0;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                snap[y*MAX_WIDTH+x] = img[y*MAX_WIDTH+x];
        for (int y = 1; y + 1 < h; y++) begin
            for (int x = 1; x + 1 < w; x++) begin
                if (snap[y*MAX_WIDTH+x] == 0) continue;
                ring[0] = snap[(y-1)*MAX_WIDTH+x-1];
                ring[1] = snap[(y-1)*MAX_WIDTH+x];
                ring[2] = snap[(y-1)*MAX_WIDTH+x+1];
                ring[3] = snap[y*MAX_WIDTH+x+1];
                ring[4] = snap[(y+1)*MAX_WIDTH+x+1];
                ring[5] = snap[(y+1)*MAX_WIDTH+x];
                ring[6] = snap[(y+1)*MAX_WIDTH+x-1];
                ring[7] = snap[y*MAX_WIDTH+x-1];
                trans = 0;
                zeros = 0;
                for (int k = 0; k < 8; k++) begin
                    if (ring[k] != ring[(k+1)%8]) trans++;
                    if (ring[k] == 0) zeros++;
                end
                if (trans == 0 || trans >= 4 || zeros < 2 || zeros > 6) continue;
                img[y*MAX_WIDTH+x] = 0;
                any = 1;
            end
        end
        return any;
    endfunction

    task automatic thin_frame();
        int w, h, pass;
        bit keep_on, a, b;
        w = size_clamp(width_reg, MAX_WIDTH);
        h = size_clamp(height_reg, MAX_HEIGHT);
        pass = 0;
        keep_on = 1;
        while (pass <= passes_reg && keep_on) begin
            a = thin_half(w, h);
            b = thin_half(w, h);
            keep_on = a || b;
            pass++;
        end
        run_changed = keep_on;
        run_passes = PASS_W'(pass);
    endtask

    always @(posedge i_clk) begin
        logic [1:0] op;
        logic [7:0] col, row, pix;
        t_status    exp_s, got;
        if (!i_rst_n) begin
            width_reg   = 9'd256;
            height_reg  = 9'd256;
            passes_reg  = '0;
            run_changed = 0;
            run_passes  = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH:  width_reg  = i_cfg_data;
                    REG_HEIGHT: height_reg = i_cfg_data;
                    REG_PASSES: passes_reg = i_cfg_data[MAXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                op  = i_s_data[1:0];
                col = i_s_data[9:2];
                row = i_s_data[17:10];
                pix = i_s_data[25:18];
                exp_s.pixel = '0;
                case (op)
                    OP_LOAD: img[int'(row)*MAX_WIDTH+col] = pix;
                    OP_RUN:  thin_frame();
                    OP_READ: exp_s.pixel = img[int'(row)*MAX_WIDTH+col];
                    default: ;
                endcase
                exp_s.changed = run_changed;
                exp_s.passes  = run_passes;
                expected_q.push_back(exp_s);
            end
            if (i_m_valid && i_m_ready) begin
                got.pixel   = i_m_data[7:0];
                got.changed = i_m_data[8];
                got.passes  = i_m_data[13:9];
                o_checked++;
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result item %h", i_m_data);
                end else begin
                    exp_s = expected_q.pop_front();
                    if (got.pixel !== exp_s.pixel || got.changed !== exp_s.changed
                            || got.passes !== exp_s.passes) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: pixel %0d/%0d changed %0d/%0d passes %0d/%0d",
                                     exp_s.pixel, got.pixel, exp_s.changed, got.changed,
                                     exp_s.passes, got.passes);
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

endmodule

>>> tb/sv/grid_map_thinning_tb.sv
// ----------------------------------------------------------------------------
// grid_map_thinning_tb
// Loads small frames of blob shapes, reads pixels back and runs the thinning
// over several frame sizes and pass limits, with random gaps and stalls on
// both streams; a separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_map_thinning_tb;
    import gmt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;
    int          errors, pending, checked;

    int          tx_mode, rx_mode;
    int          frame_w, frame_h;
    bit          frame_loaded;
    bit          written [MAX_WIDTH*MAX_HEIGHT];
    int          written_q[$];
    int          n_load, n_read, n_run, n_nop, n_setting;

    grid_map_thinning i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    grid_map_thinning_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // hold ready low for random stretches, long ones now and then
    always @(negedge i_clk) begin
        int hold;
        if (hold > 0) begin
            hold--;
            m_axis_tready = 1'b0;
        end else if (rx_mode != 0 && $urandom_range(0, 4) == 0) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] col,
                        input logic [7:0] row, input logic [7:0] pix);
        int gap;
        if (tx_mode != 0 && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {6'b0, pix, row, col, op};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        case (op)
            OP_LOAD: begin
                n_load++;
                if (!written[int'(row)*MAX_WIDTH+col]) written_q.push_back(int'(row)*MAX_WIDTH+col);
                written[int'(row)*MAX_WIDTH+col] = 1;
            end
            OP_READ: n_read++;
            OP_RUN:  n_run++;
            default: n_nop++;
        endcase
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_frame(input int w, input int h, input int mp);
        wait_idle();
        write_reg(REG_WIDTH, 9'(w));
        write_reg(REG_HEIGHT, 9'(h));
        write_reg(REG_PASSES, 9'(mp));
        frame_w = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        frame_h = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        frame_loaded = 0;
        n_setting++;
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
    endtask

    // fill the frame with a blob of one value plus some noise
    task automatic load_frame();
        int c0, c1, r0, r1;
        logic [7:0] fg, v;
        c0 = $urandom_range(0, frame_w / 2);
        c1 = $urandom_range(c0, frame_w - 1);
        r0 = $urandom_range(0, frame_h / 2);
        r1 = $urandom_range(r0, frame_h - 1);
        fg = 8'($urandom_range(1, 255));
        for (int r = 0; r < frame_h; r++) begin
            for (int c = 0; c < frame_w; c++) begin
                v = (c >= c0 && c <= c1 && r >= r0 && r <= r1) ? fg : 8'd0;
                if ($urandom_range(0, 19) == 0) v = 8'($urandom);
                send(OP_LOAD, 8'(c), 8'(r), v);
            end
        end
        frame_loaded = 1;
    endtask

    task automatic random_item();
        int sel, a;
        sel = $urandom_range(0, 99);
        if (sel < 35 && frame_loaded) begin
            send(OP_LOAD, 8'($urandom_range(0, frame_w - 1)), 8'($urandom_range(0, frame_h - 1)),
                 ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom));
        end else if (sel < 42) begin
            send(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 80) begin
            if (frame_loaded && $urandom_range(0, 2) != 0) begin
                send(OP_READ, 8'($urandom_range(0, frame_w - 1)),
                     8'($urandom_range(0, frame_h - 1)), 8'($urandom));
            end else if (written_q.size() > 0) begin
                a = written_q[$urandom_range(0, written_q.size() - 1)];
                send(OP_READ, 8'(a % MAX_WIDTH), 8'(a / MAX_WIDTH), 8'($urandom));
            end
        end else if (sel < 93) begin
            if (frame_loaded || frame_w < 3 || frame_h < 3)
                send(OP_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            send(2'd3, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_WIDTH;
        i_cfg_data    = '0;
        tx_mode = 0;
        rx_mode = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // width zero and an oversize height saturate; no interior
        set_frame(0, 511, 15);
        send(2'd3, 8'hFF, 8'hFF, 8'hFF);
        send(OP_RUN, 8'h00, 8'h00, 8'h00);
        send(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
        send(OP_LOAD, 8'h00, 8'h00, 8'h00);
        send(OP_LOAD, 8'hAA, 8'h55, 8'h5A);
        send(OP_READ, 8'hFF, 8'hFF, 8'h00);
        send(OP_READ, 8'h00, 8'h00, 8'hFF);
        send(OP_READ, 8'hAA, 8'h55, 8'h00);
        set_frame(256, 2, 0);
        send(OP_RUN, 8'h00, 8'h00, 8'h00);

        // lone pixel keeps (eight zeros), and so does the centre of a full 3x3 block (no zeros)
        set_frame(3, 3, 0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send(OP_LOAD, 8'(c), 8'(r), (r == 1 && c == 1) ? 8'd200 : 8'd0);
        frame_loaded = 1;
        send(OP_RUN, 8'h00, 8'h00, 8'h00);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send(OP_LOAD, 8'(c), 8'(r), 8'd7);
        send(OP_RUN, 8'h00, 8'h00, 8'h00);
        send(OP_READ, 8'd1, 8'd1, 8'h00);

        // one tall narrow frame at the full height
        set_frame(3, 256, 15);
        load_frame();
        send(OP_RUN, 8'h00, 8'h00, 8'h00);

        for (int p = 0; p < 8; p++) begin
            case (p % 8)
                0: set_frame($urandom_range(3, 10), $urandom_range(3, 10), 15);
                1: set_frame($urandom_range(3, 10), $urandom_range(3, 10), 0);
                2: set_frame($urandom_range(1, 2), $urandom_range(1, 511), $urandom_range(0, 15));
                3: set_frame($urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(1, 3));
                default: set_frame($urandom_range(3, 10), $urandom_range(3, 10),
                                   $urandom_range(0, 15));
            endcase
            if (frame_w >= 3 && frame_h >= 3) load_frame();
            repeat (40) random_item();
        end

        wait_idle();
        repeat (50) @(negedge i_clk);
        $display("%0d loads, %0d reads, %0d runs, %0d idle ops over %0d frame settings",
                 n_load, n_read, n_run, n_nop, n_setting);
        $display("%0d result items checked, %0d mismatches", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #300_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> grid_map_thinning.f
rtl/core/gmt_pkg.sv
rtl/core/gmt_ram.sv
rtl/core/gmt_engine.sv
rtl/core/grid_map_thinning.sv
rtl/core/gmt_checker.sv
tb/sv/grid_map_thinning_checker.sv
tb/sv/grid_map_thinning_tb.sv
